// ===== rtl/core/tdrm_pkg.sv =====
// ----------------------------------------------------------------------------
// tdrm_pkg
// Shared types, constants and state encodings of the triangle depth rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdrm_pkg;

	localparam int GRID_SIZE  = 128;
	localparam int COORD_W    = $clog2(GRID_SIZE);
	localparam int ADDR_W     = 2 * COORD_W;
	localparam int DEPTH_BITS = 16;
	localparam int AREA_W     = 2 * COORD_W + 1;
	localparam int SUM_W      = AREA_W + 2;
	localparam int ACC_W      = AREA_W + DEPTH_BITS + 2;
	localparam int DEC_W      = COORD_W + 4;
	localparam int QSTEP_W    = $clog2(DEPTH_BITS);

	typedef logic [COORD_W-1:0]    coord_t;
	typedef logic [DEPTH_BITS-1:0] depth_t;
	typedef logic [ADDR_W-1:0]     addr_t;

	localparam coord_t COORD_MAX = COORD_W'(GRID_SIZE - 1);

	localparam logic KIND_DRAW = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic           is_read;
		coord_t [2:0]   vr;
		coord_t [2:0]   vc;
		depth_t [2:0]   vd;
		coord_t         rlo;
		coord_t         rhi;
		coord_t         clo;
		coord_t         chi;
		coord_t         rd_row;
		coord_t         rd_col;
	} item_t;

	typedef enum logic [1:0] {
		IP_IDLE,
		IP_MAC,
		IP_RND,
		IP_DIV
	} ip_state_t;

	typedef enum logic [3:0] {
		BK_MAPCLR,
		BK_IDLE,
		BK_RDDATA,
		BK_CLR,
		BK_SEED,
		BK_EDGE_SET,
		BK_EDGE_RUN,
		BK_EDGE_WAIT,
		BK_SCAN_ADDR,
		BK_SCAN_DATA,
		BK_FILL_ADDR,
		BK_FILL_DATA,
		BK_FILL_WAIT,
		BK_MRG_ADDR,
		BK_MRG_DATA
	} bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tdrm_front.sv =====
// ----------------------------------------------------------------------------
// tdrm_front
// Accepts requests, classifies them and computes the grown, clipped box.
// ----------------------------------------------------------------------------
`default_nettype none

module tdrm_front import tdrm_pkg::*; (
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire logic   kind,
	input  wire coord_t vert0_row,
	input  wire coord_t vert0_col,
	input  wire depth_t vert0_depth,
	input  wire coord_t vert1_row,
	input  wire coord_t vert1_col,
	input  wire depth_t vert1_depth,
	input  wire coord_t vert2_row,
	input  wire coord_t vert2_col,
	input  wire depth_t vert2_depth,
	input  wire coord_t read_row,
	input  wire coord_t read_col,
	input  wire logic   full,
	output logic        push,
	output item_t       push_item
);

	function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (b < a) ? b : a;
		min3 = (c < m) ? c : m;
	endfunction

	function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (b > a) ? b : a;
		max3 = (c > m) ? c : m;
	endfunction

	coord_t top, bottom, left, right;

	assign top    = min3(vert0_row, vert1_row, vert2_row);
	assign bottom = max3(vert0_row, vert1_row, vert2_row);
	assign left   = min3(vert0_col, vert1_col, vert2_col);
	assign right  = max3(vert0_col, vert1_col, vert2_col);

	assign in_ready = !full;
	assign push     = in_valid && !full;

	always_comb begin
		push_item.is_read = (kind == KIND_READ);
		push_item.vr      = {vert2_row, vert1_row, vert0_row};
		push_item.vc      = {vert2_col, vert1_col, vert0_col};
		push_item.vd      = {vert2_depth, vert1_depth, vert0_depth};
		push_item.rlo     = (top == '0) ? '0 : top - 1'b1;
		push_item.rhi     = (bottom == COORD_MAX) ? COORD_MAX : bottom + 1'b1;
		push_item.clo     = (left == '0) ? '0 : left - 1'b1;
		push_item.chi     = (right == COORD_MAX) ? COORD_MAX : right + 1'b1;
		push_item.rd_row  = read_row;
		push_item.rd_col  = read_col;
	end

endmodule

`default_nettype wire

// ===== rtl/core/tdrm_fifo.sv =====
// ----------------------------------------------------------------------------
// tdrm_fifo
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tdrm_fifo import tdrm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output item_t      head,
	output logic       empty
);

	item_t      entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_item;
	end

endmodule

`default_nettype wire

// ===== rtl/core/tdrm_interp.sv =====
// ----------------------------------------------------------------------------
// tdrm_interp
// Barycentric depth unit: areas, serial multiply-accumulate, restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module tdrm_interp import tdrm_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire coord_t       row,
	input  wire coord_t       col,
	input  wire coord_t [2:0] vr,
	input  wire coord_t [2:0] vc,
	input  wire depth_t [2:0] dv,
	output logic              done,
	output depth_t            value
);

	function automatic logic [AREA_W-1:0] twice_area(input coord_t ra, input coord_t ca,
			input coord_t rb, input coord_t cb, input coord_t r, input coord_t c);
		logic signed [COORD_W:0]     dra, dca, drb, dcb;
		logic signed [2*COORD_W+1:0] p, q, v;
		dra = $signed({1'b0, ra}) - $signed({1'b0, r});
		dca = $signed({1'b0, ca}) - $signed({1'b0, c});
		drb = $signed({1'b0, rb}) - $signed({1'b0, r});
		dcb = $signed({1'b0, cb}) - $signed({1'b0, c});
		p = dra * dcb;
		q = drb * dca;
		v = p - q;
		twice_area = v[2*COORD_W+1] ? AREA_W'(-v) : AREA_W'(v);
	endfunction

	ip_state_t               state_q, state_d;
	logic [1:0]              mac_q;
	logic [QSTEP_W-1:0]      bit_q;
	logic                    done_q;
	logic [AREA_W-1:0]       a_q [3];
	depth_t                  dl_q [3];
	logic [SUM_W-1:0]        s_q;
	logic [ACC_W-1:0]        acc_q;
	logic [SUM_W-1:0]        rem_q;
	depth_t                  quo_q;
	depth_t                  value_q;

	logic [AREA_W-1:0]            a0, a1, a2;
	logic [AREA_W+DEPTH_BITS-1:0] prod;
	logic [ACC_W-1:0]             num;
	logic [SUM_W:0]               rem_ext, rem_sub;
	logic                         ge;

	assign a0      = twice_area(vr[1], vc[1], vr[2], vc[2], row, col);
	assign a1      = twice_area(vr[0], vc[0], vr[2], vc[2], row, col);
	assign a2      = twice_area(vr[0], vc[0], vr[1], vc[1], row, col);
	assign prod    = a_q[mac_q] * dl_q[mac_q];
	assign num     = acc_q + ACC_W'(s_q >> 1);
	assign rem_ext = {rem_q, quo_q[DEPTH_BITS-1]};
	assign rem_sub = rem_ext - {1'b0, s_q};
	assign ge      = (rem_ext >= {1'b0, s_q});

	assign done  = done_q;
	assign value = value_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			IP_IDLE: if (start) state_d = IP_MAC;
			IP_MAC:  if (mac_q == 2'd2) state_d = IP_RND;
			IP_RND:  state_d = IP_DIV;
			IP_DIV:  if (bit_q == QSTEP_W'(DEPTH_BITS - 1)) state_d = IP_IDLE;
			default: state_d = IP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IP_IDLE;
			mac_q   <= 2'd0;
			bit_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == IP_DIV) && (bit_q == QSTEP_W'(DEPTH_BITS - 1));
			if (state_q == IP_IDLE) mac_q <= 2'd0;
			else if (state_q == IP_MAC) mac_q <= mac_q + 2'd1;
			if (state_q == IP_DIV) bit_q <= bit_q + 1'b1;
			else bit_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			IP_IDLE: begin
				a_q[0]  <= a0;
				a_q[1]  <= a1;
				a_q[2]  <= a2;
				dl_q[0] <= dv[0];
				dl_q[1] <= dv[1];
				dl_q[2] <= dv[2];
				s_q     <= SUM_W'(a0) + SUM_W'(a1) + SUM_W'(a2);
				acc_q   <= '0;
			end
			IP_MAC: acc_q <= acc_q + ACC_W'(prod);
			IP_RND: begin
				rem_q <= num[ACC_W-1:DEPTH_BITS];
				quo_q <= num[DEPTH_BITS-1:0];
			end
			IP_DIV: begin
				rem_q <= ge ? rem_sub[SUM_W-1:0] : rem_ext[SUM_W-1:0];
				quo_q <= {quo_q[DEPTH_BITS-2:0], ge};
				if (bit_q == QSTEP_W'(DEPTH_BITS - 1))
					value_q <= (s_q == '0) ? dl_q[0] : {quo_q[DEPTH_BITS-2:0], ge};
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/tdrm_back.sv =====
// ----------------------------------------------------------------------------
// tdrm_back
// Sequencer: map clear after reset, scratch clear, seeding, edge walk, row fill, depth map merge, reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tdrm_back import tdrm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t head,
	input  wire logic  empty,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output depth_t     cell_depth
);

	depth_t scr_mem [GRID_SIZE*GRID_SIZE];
	depth_t map_mem [GRID_SIZE*GRID_SIZE];

	bk_state_t state_q, state_d;
	item_t     item_q;
	coord_t    r_q, c_q;
	logic [1:0] k_q;
	logic      found_q;
	coord_t    lft_q, rgt_q;
	depth_t    d_q [3];
	coord_t    x_q, y_q, ex_q, ey_q;
	logic [1:0] sx_q, sy_q;
	logic [COORD_W:0] ax_q, ay_q;
	logic signed [DEC_W-1:0] dec_q;
	logic      xmode_q;
	logic      out_valid_q;
	depth_t    cell_depth_q;

	logic   scr_we, map_we;
	addr_t  scr_waddr, scr_raddr, map_waddr, map_raddr;
	depth_t scr_wdata, map_wdata;
	depth_t scr_rdata_q, map_rdata_q;

	logic   ip_start, ip_done;
	coord_t ip_row, ip_col;
	depth_t ip_value;

	logic at_end_col, at_end_row, box_last, edge_end, nz, found_now, row_end;
	coord_t fill_lft;

	logic [1:0] ej, efrom, eto;
	coord_t fr, fc, tr, tc;
	logic signed [COORD_W:0] edx, edy;
	coord_t adx, ady;
	logic ex_mode;
	logic signed [DEC_W-1:0] ax_e, ay_e, adx_e, ady_e, ax_s, ay_s;

	assign at_end_col = (c_q == item_q.chi);
	assign at_end_row = (r_q == item_q.rhi);
	assign box_last   = at_end_col && at_end_row;
	assign edge_end   = xmode_q ? (x_q == ex_q) : (y_q == ey_q);
	assign nz         = (scr_rdata_q != '0);
	assign found_now  = found_q || nz;
	assign fill_lft   = found_q ? lft_q : c_q;
	assign row_end    = (c_q == rgt_q);

	assign ej    = (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
	assign efrom = (item_q.vr[k_q] < item_q.vr[ej]) ? k_q : ej;
	assign eto   = (item_q.vr[k_q] < item_q.vr[ej]) ? ej : k_q;
	assign fr    = item_q.vr[efrom];
	assign fc    = item_q.vc[efrom];
	assign tr    = item_q.vr[eto];
	assign tc    = item_q.vc[eto];
	assign edx   = $signed({1'b0, tc}) - $signed({1'b0, fc});
	assign edy   = $signed({1'b0, tr}) - $signed({1'b0, fr});
	assign adx   = edx[COORD_W] ? COORD_W'(-edx) : COORD_W'(edx);
	assign ady   = edy[COORD_W] ? COORD_W'(-edy) : COORD_W'(edy);
	assign ex_mode = (ady <= adx);
	assign adx_e = $signed({{(DEC_W-COORD_W){1'b0}}, adx});
	assign ady_e = $signed({{(DEC_W-COORD_W){1'b0}}, ady});
	assign ax_e  = adx_e <<< 1;
	assign ay_e  = ady_e <<< 1;
	assign ax_s  = $signed({{(DEC_W-COORD_W-1){1'b0}}, ax_q});
	assign ay_s  = $signed({{(DEC_W-COORD_W-1){1'b0}}, ay_q});

	assign out_valid  = out_valid_q;
	assign cell_depth = cell_depth_q;

	tdrm_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ip_start),
		.row    (ip_row),
		.col    (ip_col),
		.vr     (item_q.vr),
		.vc     (item_q.vc),
		.dv     ({d_q[2], d_q[1], d_q[0]}),
		.done   (ip_done),
		.value  (ip_value)
	);

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		scr_we    = 1'b0;
		scr_waddr = {r_q, c_q};
		scr_wdata = '0;
		scr_raddr = {r_q, c_q};
		map_we    = 1'b0;
		map_waddr = {r_q, c_q};
		map_wdata = '0;
		map_raddr = {r_q, c_q};
		ip_start  = 1'b0;
		ip_row    = y_q;
		ip_col    = x_q;
		unique case (state_q)
			BK_MAPCLR: begin
				map_we = 1'b1;
				if (r_q == COORD_MAX && c_q == COORD_MAX) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				map_raddr = {head.rd_row, head.rd_col};
				if (!empty) begin
					if (head.is_read) begin
						if (!out_valid_q) begin
							pop     = 1'b1;
							state_d = BK_RDDATA;
						end
					end else begin
						pop     = 1'b1;
						state_d = BK_CLR;
					end
				end
			end
			BK_RDDATA: state_d = BK_IDLE;
			BK_CLR: begin
				scr_we = 1'b1;
				if (box_last) state_d = BK_SEED;
			end
			BK_SEED: begin
				scr_we    = 1'b1;
				scr_waddr = {item_q.vr[k_q], item_q.vc[k_q]};
				scr_wdata = item_q.vd[k_q];
				if (k_q == 2'd2) state_d = BK_EDGE_SET;
			end
			BK_EDGE_SET: state_d = BK_EDGE_RUN;
			BK_EDGE_RUN: begin
				ip_start = 1'b1;
				state_d  = BK_EDGE_WAIT;
			end
			BK_EDGE_WAIT: begin
				if (ip_done) begin
					scr_we    = 1'b1;
					scr_waddr = {y_q, x_q};
					scr_wdata = ip_value;
					if (!edge_end) state_d = BK_EDGE_RUN;
					else if (k_q == 2'd2) state_d = BK_SCAN_ADDR;
					else state_d = BK_EDGE_SET;
				end
			end
			BK_SCAN_ADDR: state_d = BK_SCAN_DATA;
			BK_SCAN_DATA: begin
				if (!at_end_col) state_d = BK_SCAN_ADDR;
				else if (found_now) state_d = BK_FILL_ADDR;
				else if (at_end_row) state_d = BK_MRG_ADDR;
				else state_d = BK_SCAN_ADDR;
			end
			BK_FILL_ADDR: state_d = BK_FILL_DATA;
			BK_FILL_DATA: begin
				ip_row = r_q;
				ip_col = c_q;
				if (!nz) begin
					ip_start = 1'b1;
					state_d  = BK_FILL_WAIT;
				end else if (!row_end) state_d = BK_FILL_ADDR;
				else if (at_end_row) state_d = BK_MRG_ADDR;
				else state_d = BK_SCAN_ADDR;
			end
			BK_FILL_WAIT: begin
				ip_row = r_q;
				ip_col = c_q;
				if (ip_done) begin
					scr_we    = 1'b1;
					scr_wdata = ip_value;
					if (!row_end) state_d = BK_FILL_ADDR;
					else if (at_end_row) state_d = BK_MRG_ADDR;
					else state_d = BK_SCAN_ADDR;
				end
			end
			BK_MRG_ADDR: state_d = BK_MRG_DATA;
			BK_MRG_DATA: begin
				if (scr_rdata_q > map_rdata_q) begin
					map_we    = 1'b1;
					map_wdata = scr_rdata_q;
				end
				state_d = box_last ? BK_IDLE : BK_MRG_ADDR;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_MAPCLR;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= 2'd0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_RDDATA) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q) inside
				BK_MAPCLR: begin
					c_q <= c_q + 1'b1;
					if (c_q == COORD_MAX) r_q <= r_q + 1'b1;
				end
				BK_IDLE: begin
					if (!empty && !head.is_read) begin
						r_q <= head.rlo;
						c_q <= head.clo;
					end
				end
				BK_CLR, BK_MRG_DATA: begin
					k_q <= 2'd0;
					if (at_end_col) begin
						c_q <= item_q.clo;
						r_q <= r_q + 1'b1;
					end else c_q <= c_q + 1'b1;
				end
				BK_SEED: k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				BK_EDGE_WAIT: begin
					if (ip_done && edge_end) begin
						if (k_q == 2'd2) begin
							r_q     <= item_q.rlo;
							c_q     <= item_q.clo;
							found_q <= 1'b0;
						end else k_q <= k_q + 2'd1;
					end
				end
				BK_SCAN_DATA: begin
					if (nz) found_q <= 1'b1;
					if (!at_end_col) c_q <= c_q + 1'b1;
					else if (found_now) c_q <= fill_lft;
					else begin
						c_q     <= item_q.clo;
						r_q     <= at_end_row ? item_q.rlo : r_q + 1'b1;
						found_q <= 1'b0;
					end
				end
				BK_FILL_DATA, BK_FILL_WAIT: begin
					if ((state_q == BK_FILL_DATA && nz) || (state_q == BK_FILL_WAIT && ip_done))
					begin
						if (!row_end) c_q <= c_q + 1'b1;
						else begin
							c_q     <= item_q.clo;
							r_q     <= at_end_row ? item_q.rlo : r_q + 1'b1;
							found_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && !empty && !head.is_read) item_q <= head;
		if (state_q == BK_RDDATA) cell_depth_q <= map_rdata_q;
		if (state_q == BK_SCAN_DATA && nz) begin
			if (!found_q) lft_q <= c_q;
			rgt_q <= c_q;
		end
		if (state_q == BK_EDGE_SET) begin
			x_q     <= fc;
			y_q     <= fr;
			ex_q    <= tc;
			ey_q    <= tr;
			sx_q    <= edx[COORD_W] ? 2'b11 : ((edx != '0) ? 2'b01 : 2'b00);
			sy_q    <= edy[COORD_W] ? 2'b11 : ((edy != '0) ? 2'b01 : 2'b00);
			ax_q    <= {adx, 1'b0};
			ay_q    <= {ady, 1'b0};
			xmode_q <= ex_mode;
			dec_q   <= ex_mode ? (ay_e - adx_e) : (ax_e - ady_e);
		end
		if (state_q == BK_EDGE_WAIT && ip_done && !edge_end) begin
			if (xmode_q) begin
				x_q <= x_q + {{(COORD_W-2){sx_q[1]}}, sx_q};
				if (!dec_q[DEC_W-1]) begin
					dec_q <= dec_q - ax_s + ay_s;
					y_q   <= y_q + {{(COORD_W-2){sy_q[1]}}, sy_q};
				end else dec_q <= dec_q + ay_s;
			end else begin
				y_q <= y_q + {{(COORD_W-2){sy_q[1]}}, sy_q};
				if (!dec_q[DEC_W-1]) begin
					dec_q <= dec_q - ay_s + ax_s;
					x_q   <= x_q + {{(COORD_W-2){sx_q[1]}}, sx_q};
				end else dec_q <= dec_q + ax_s;
			end
		end
		if (scr_we) begin
			for (int k = 0; k < 3; k++)
				if ({item_q.vr[k], item_q.vc[k]} == scr_waddr) d_q[k] <= scr_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
		scr_rdata_q <= scr_mem[scr_raddr];
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wdata;
		map_rdata_q <= map_mem[map_raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/triangle_depth_raster_max.sv =====
// ----------------------------------------------------------------------------
// triangle_depth_raster_max
// Triangle rasterizer with barycentric depth, max-merged into a depth map.
//
//   channel   signals                         payload
//   request   in_valid / in_ready             kind, vertK_row/col/depth, read_row/col
//   result    out_valid / out_ready           cell_depth (read requests only)
//
// After reset the whole depth map is cleared before the first request is served.
// A read passes the idle and read-data states into the result register. A draw
// clears, scans and merges each cell of the grown box, and runs the depth unit
// with its 16-step divider for each edge or fill cell. A two-entry queue takes
// requests while the back is busy; the result register holds while out_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_depth_raster_max import tdrm_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire logic   kind,
	input  wire coord_t vert0_row,
	input  wire coord_t vert0_col,
	input  wire depth_t vert0_depth,
	input  wire coord_t vert1_row,
	input  wire coord_t vert1_col,
	input  wire depth_t vert1_depth,
	input  wire coord_t vert2_row,
	input  wire coord_t vert2_col,
	input  wire depth_t vert2_depth,
	input  wire coord_t read_row,
	input  wire coord_t read_col,
	output logic        out_valid,
	input  wire logic   out_ready,
	output depth_t      cell_depth
);

	logic  push, full, pop, empty;
	item_t push_item, head;

	tdrm_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.vert0_row   (vert0_row),
		.vert0_col   (vert0_col),
		.vert0_depth (vert0_depth),
		.vert1_row   (vert1_row),
		.vert1_col   (vert1_col),
		.vert1_depth (vert1_depth),
		.vert2_row   (vert2_row),
		.vert2_col   (vert2_col),
		.vert2_depth (vert2_depth),
		.read_row    (read_row),
		.read_col    (read_col),
		.full        (full),
		.push        (push),
		.push_item   (push_item)
	);

	tdrm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	tdrm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_depth (cell_depth)
	);

endmodule

`default_nettype wire

// ===== test/triangle_depth_raster_max_chk.sv =====
// ----------------------------------------------------------------------------
// triangle_depth_raster_max_chk
// Watches both channels of the rasterizer and predicts every read result.
// Each accepted draw request is rasterized into a private depth map. Each
// accepted read request queues the predicted cell depth. Every accepted result
// is compared with the oldest queued depth.
// ----------------------------------------------------------------------------
module triangle_depth_raster_max_chk import tdrm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   in_ready,
	input  logic   kind,
	input  coord_t vert0_row,
	input  coord_t vert0_col,
	input  depth_t vert0_depth,
	input  coord_t vert1_row,
	input  coord_t vert1_col,
	input  depth_t vert1_depth,
	input  coord_t vert2_row,
	input  coord_t vert2_col,
	input  depth_t vert2_depth,
	input  coord_t read_row,
	input  coord_t read_col,
	input  logic   out_valid,
	input  logic   out_ready,
	input  depth_t cell_depth,
	output int     fail_count,
	output int     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	depth_t map_model [GRID_SIZE*GRID_SIZE];
	int     scratch [GRID_SIZE][GRID_SIZE];
	int     tri_row [3];
	int     tri_col [3];
	depth_t expected_depths [$];

	assign pending = expected_depths.size();

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic int scr_get(input int r, input int c);
		if (r < 0 || c < 0 || r >= GRID_SIZE || c >= GRID_SIZE)
			return 0;
		return scratch[r][c];
	endfunction

	function automatic longint twice_area(input int ra, ca, rb, cb, r, c);
		longint v;
		v = longint'(ra) * cb - longint'(rb) * ca + longint'(c) * rb
			- longint'(r) * cb + longint'(r) * ca - longint'(c) * ra;
		return v < 0 ? -v : v;
	endfunction

	function automatic int bary_depth(input int r, input int c);
		longint a0, a1, a2, s, d0, d1, d2;
		a0 = twice_area(tri_row[1], tri_col[1], tri_row[2], tri_col[2], r, c);
		a1 = twice_area(tri_row[0], tri_col[0], tri_row[2], tri_col[2], r, c);
		a2 = twice_area(tri_row[0], tri_col[0], tri_row[1], tri_col[1], r, c);
		s = a0 + a1 + a2;
		d0 = scr_get(tri_row[0], tri_col[0]);
		d1 = scr_get(tri_row[1], tri_col[1]);
		d2 = scr_get(tri_row[2], tri_col[2]);
		if (s == 0)
			return int'(d0);
		return int'((a0 * d0 + a1 * d1 + a2 * d2 + s / 2) / s);
	endfunction

	task automatic walk_edge(input int r0, c0, r1, c1);
		int x, y, dx, dy, sx, sy, ax, ay, dec;
		x = c0;
		y = r0;
		dx = c1 - c0;
		dy = r1 - r0;
		sx = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
		sy = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		ax = 2 * dx;
		ay = 2 * dy;
		if (dy <= dx) begin
			dec = ay - dx;
			while (1) begin
				scratch[y][x] = bary_depth(y, x);
				if (x == c1) break;
				if (dec >= 0) begin
					dec -= ax;
					y += sy;
				end
				x += sx;
				dec += ay;
			end
		end else begin
			dec = ax - dy;
			while (1) begin
				scratch[y][x] = bary_depth(y, x);
				if (y == r1) break;
				if (dec >= 0) begin
					dec -= ay;
					x += sx;
				end
				y += sy;
				dec += ax;
			end
		end
	endtask

	task automatic rasterize(input coord_t rw [3], input coord_t cl [3], input depth_t dp [3]);
		int top, bot, lef, rig, rlo, rhi, clo, chi, lft, rgt, j;
		for (int r = 0; r < GRID_SIZE; r++)
			for (int c = 0; c < GRID_SIZE; c++)
				scratch[r][c] = 0;
		for (int k = 0; k < 3; k++) begin
			tri_row[k] = rw[k];
			tri_col[k] = cl[k];
		end
		top = tri_row[0];
		bot = tri_row[0];
		lef = tri_col[0];
		rig = tri_col[0];
		for (int k = 0; k < 3; k++) begin
			scratch[tri_row[k]][tri_col[k]] = dp[k];
			if (tri_col[k] < lef) lef = tri_col[k];
			if (tri_col[k] > rig) rig = tri_col[k];
			if (tri_row[k] < top) top = tri_row[k];
			if (tri_row[k] > bot) bot = tri_row[k];
		end
		for (int k = 0; k < 3; k++) begin
			j = (k + 1) % 3;
			if (tri_row[k] < tri_row[j])
				walk_edge(tri_row[k], tri_col[k], tri_row[j], tri_col[j]);
			else
				walk_edge(tri_row[j], tri_col[j], tri_row[k], tri_col[k]);
		end
		rlo = top > 0 ? top - 1 : 0;
		rhi = bot < GRID_SIZE - 1 ? bot + 1 : GRID_SIZE - 1;
		clo = lef > 0 ? lef - 1 : 0;
		chi = rig < GRID_SIZE - 1 ? rig + 1 : GRID_SIZE - 1;
		for (int r = rlo; r <= rhi; r++) begin
			lft = -1;
			rgt = -1;
			for (int c = clo; c <= chi; c++)
				if (scratch[r][c] != 0) begin
					if (lft < 0) lft = c;
					rgt = c;
				end
			if (lft >= 0)
				for (int c = lft; c <= rgt; c++)
					if (scratch[r][c] == 0)
						scratch[r][c] = bary_depth(r, c);
		end
		for (int r = rlo; r <= rhi; r++)
			for (int c = clo; c <= chi; c++)
				if (scratch[r][c] != 0 && scratch[r][c] > map_model[r*GRID_SIZE+c])
					map_model[r*GRID_SIZE+c] = depth_t'(scratch[r][c]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GRID_SIZE*GRID_SIZE; i++)
				map_model[i] = '0;
			expected_depths.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_depths.size() == 0)
					report_mismatch($sformatf("unexpected result cell_depth=%0h", cell_depth));
				else begin
					if (cell_depth !== expected_depths[0])
						report_mismatch($sformatf("cell_depth %0h, predicted %0h",
							cell_depth, expected_depths[0]));
					void'(expected_depths.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				if (kind == KIND_READ)
					expected_depths.push_back(map_model[read_row*GRID_SIZE+read_col]);
				else
					rasterize('{vert0_row, vert1_row, vert2_row},
						'{vert0_col, vert1_col, vert2_col},
						'{vert0_depth, vert1_depth, vert2_depth});
			end
		end
	end
endmodule

// ===== test/triangle_depth_raster_max_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_depth_raster_max_tb
// Stimulus and verdict for the triangle depth rasterizer.
// Directed draws cover full-grid, point, line, shared-vertex, zero-depth and
// edge-of-grid triangles; random phases mix small triangles with reads near
// them under varying sender and receiver idling. Checking lives in the checker.
// ----------------------------------------------------------------------------
module triangle_depth_raster_max_tb;
	import tdrm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	logic   kind = KIND_READ;
	coord_t vert0_row = '0, vert0_col = '0, vert1_row = '0, vert1_col = '0;
	coord_t vert2_row = '0, vert2_col = '0, read_row = '0, read_col = '0;
	depth_t vert0_depth = '0, vert1_depth = '0, vert2_depth = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	depth_t cell_depth;
	int     fail_count, pending;
	int     send_idle_pct = 0, recv_stall_pct = 0;
	int     near_row = 0, near_col = 0;

	triangle_depth_raster_max dut (.*);

	triangle_depth_raster_max_chk chk (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= $urandom_range(99) >= recv_stall_pct;

	initial begin
		#200ms;
		$display("triangle_depth_raster_max_tb failed");
		$finish;
	end

	task automatic send_request(input logic k, input int r0, c0, d0, r1, c1, d1,
		input int r2, c2, d2, rr, rc);
		logic rdy;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		vert0_row <= coord_t'(r0); vert0_col <= coord_t'(c0); vert0_depth <= depth_t'(d0);
		vert1_row <= coord_t'(r1); vert1_col <= coord_t'(c1); vert1_depth <= depth_t'(d1);
		vert2_row <= coord_t'(r2); vert2_col <= coord_t'(c2); vert2_depth <= depth_t'(d2);
		read_row <= coord_t'(rr); read_col <= coord_t'(rc);
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic draw_tri(input int r0, c0, d0, r1, c1, d1, r2, c2, d2);
		send_request(KIND_DRAW, r0, c0, d0, r1, c1, d1, r2, c2, d2,
			$urandom_range(127), $urandom_range(127));
	endtask

	task automatic read_cell(input int rr, rc);
		send_request(KIND_READ, $urandom_range(127), $urandom_range(127), $urandom,
			$urandom_range(127), $urandom_range(127), $urandom,
			$urandom_range(127), $urandom_range(127), $urandom, rr, rc);
	endtask

	function automatic int clamp_coord(input int v);
		return v > 127 ? 127 : v;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int br, bc;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		read_cell(0, 0);
		read_cell(127, 127);
		draw_tri(0, 0, 65535, 0, 127, 1, 127, 0, 32768);
		read_cell(0, 0);
		read_cell(0, 127);
		read_cell(64, 32);
		draw_tri(10, 0, 100, 14, 0, 200, 12, 3, 300);
		read_cell(12, 0);
		draw_tri(50, 50, 1234, 50, 50, 4321, 50, 50, 777);
		read_cell(50, 50);
		draw_tri(20, 20, 500, 25, 25, 900, 30, 30, 100);
		read_cell(25, 25);
		draw_tri(70, 70, 0, 72, 75, 0, 76, 71, 1);
		read_cell(72, 72);
		draw_tri(90, 90, 0, 90, 90, 5000, 95, 96, 6000);
		read_cell(90, 90);
		draw_tri(120, 120, 65535, 127, 127, 65535, 127, 120, 65535);
		read_cell(127, 127);
		read_cell(126, 124);
		for (int phase = 0; phase < 4; phase++) begin
			drain();
			send_idle_pct = phase == 1 ? 71 : (phase == 3 ? 16 : 0);
			recv_stall_pct = phase == 2 ? 71 : (phase == 3 ? 16 : 0);
			for (int n = 0; n < 20; n++) begin
				if ($urandom_range(99) < 40) begin
					br = $urandom_range(127);
					bc = $urandom_range(127);
					near_row = br;
					near_col = bc;
					draw_tri(br, bc, $urandom,
						clamp_coord(br + $urandom_range(10)),
						clamp_coord(bc + $urandom_range(10)), $urandom,
						clamp_coord(br + $urandom_range(10)),
						clamp_coord(bc + $urandom_range(10)), $urandom);
				end else if ($urandom_range(99) < 70) begin
					read_cell(clamp_coord(near_row + $urandom_range(11)),
						clamp_coord(near_col + $urandom_range(11)));
				end else begin
					read_cell($urandom_range(127), $urandom_range(127));
				end
			end
		end
		read_cell(near_row, near_col);
		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("triangle_depth_raster_max_tb passed");
		else
			$display("triangle_depth_raster_max_tb failed");
		$finish;
	end
endmodule
